[hdl/gdc_pkg.sv]
package gdc_pkg;

  localparam int GRID_ROWS   = 33;
  localparam int GRID_COLS   = 33;
  localparam int ROW_W       = $clog2(GRID_ROWS);
  localparam int COL_W       = $clog2(GRID_COLS);
  localparam int CELLS       = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int STACK_DEPTH = 256;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = SP_W + 1;
  localparam int ENTRY_W     = ROW_W + COL_W;
  localparam int RND_W       = 16;
  localparam int OUT_COORD_W = 6;
  localparam int OUT_DEPTH_W = 9;

  // linear index of the start cell (1,1)
  localparam logic [ADDR_W-1:0] START_ADDR = ADDR_W'(GRID_COLS + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);

  typedef enum logic [1:0] {
    ACT_CARVE = 2'd0,
    ACT_BACK  = 2'd1,
    ACT_START = 2'd2,
    ACT_DONE  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_OPEN11,
    ST_TOPRD,
    ST_NB,
    ST_PICK,
    ST_OPENC,
    ST_OPENW,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             ok;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } step_t;

endpackage

[hdl/gdc_ram.sv]
module gdc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/gdc_step_unit.sv]
module gdc_step_unit (
  input  logic [gdc_pkg::ROW_W-1:0]  base_row,
  input  logic [gdc_pkg::COL_W-1:0]  base_col,
  input  gdc_pkg::dir_t              dir,
  input  logic                       far,
  output gdc_pkg::step_t             res,
  output logic [gdc_pkg::ADDR_W-1:0] addr
);
  import gdc_pkg::*;

  localparam logic [ROW_W:0]      ROWS_X = (ROW_W + 1)'(GRID_ROWS);
  localparam logic [COL_W:0]      COLS_X = (COL_W + 1)'(GRID_COLS);
  localparam logic [ADDR_W-1:0]   COLS_A = ADDR_W'(GRID_COLS);

  logic [ROW_W:0] row_x, dist_r, nrow;
  logic [COL_W:0] col_x, dist_c, ncol;
  logic           ok;

  always_comb begin
    row_x  = {1'b0, base_row};
    col_x  = {1'b0, base_col};
    dist_r = far ? (ROW_W + 1)'(2) : (ROW_W + 1)'(1);
    dist_c = far ? (COL_W + 1)'(2) : (COL_W + 1)'(1);
    nrow   = row_x;
    ncol   = col_x;
    ok     = 1'b0;
    case (dir)
      DIR_UP: begin
        ok   = row_x >= dist_r;
        nrow = row_x - dist_r;
      end
      DIR_LEFT: begin
        ok   = col_x >= dist_c;
        ncol = col_x - dist_c;
      end
      DIR_RIGHT: begin
        ncol = col_x + dist_c;
        ok   = ncol < COLS_X;
      end
      DIR_DOWN: begin
        nrow = row_x + dist_r;
        ok   = nrow < ROWS_X;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    res.ok  = ok;
    res.row = nrow[ROW_W-1:0];
    res.col = ncol[COL_W-1:0];
    // row-major cell index, one constant multiply
    addr    = ADDR_W'(res.row) * COLS_A + ADDR_W'(res.col);
  end

endmodule

[hdl/gdc_pick.sv]
module gdc_pick (
  input  logic [3:0]               mask,
  input  logic [gdc_pkg::RND_W-1:0] rnd,
  output gdc_pkg::dir_t            sel
);
  import gdc_pkg::*;

  // 4 is 1 mod 3, so the base-4 digit sum keeps the residue
  function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < RND_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  logic [2:0] n;
  logic [1:0] k;
  logic [2:0] seen;

  always_comb begin
    n = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
    case (n)
      3'd2:    k = {1'b0, rnd[0]};
      3'd3:    k = mod3(rnd);
      3'd4:    k = rnd[1:0];
      default: k = 2'd0;
    endcase
    // k-th candidate in up, left, right, down order
    sel  = DIR_UP;
    seen = '0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (seen == {1'b0, k}) begin
          sel = dir_t'(2'(i));
        end
        seen = seen + 3'd1;
      end
    end
  end

endmodule

[hdl/grid_maze_dfs_carver_core.sv]
// channel  direction  handshake             payload
// in_      input      in_valid / in_stall    in_restart, in_random_value
// out_     output     out_valid / out_stall  out_action, out_cell_row, out_cell_col,
//                                            out_wall_row, out_wall_col, out_depth_now
//
// a restart beat sweeps the grid memory to wall, one cell a cycle, before its result is loaded
// a search step reads the stack top, then the four neighbour bits through the single
// grid read port, one a cycle; a step on an empty stack skips both and goes to its result
// in_stall is low only while the sequencer is idle; a result waiting under out_stall
// does not block the next input beat, only the load of its result
// rst_n clears the sequencer, stack count and output valid; grid memory is not swept
// until the first restart, and a step before it answers done
module grid_maze_dfs_carver_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_restart,
  input  logic [gdc_pkg::RND_W-1:0]       in_random_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_action,
  output logic [gdc_pkg::OUT_COORD_W-1:0] out_cell_row,
  output logic [gdc_pkg::OUT_COORD_W-1:0] out_cell_col,
  output logic [gdc_pkg::OUT_COORD_W-1:0] out_wall_row,
  output logic [gdc_pkg::OUT_COORD_W-1:0] out_wall_col,
  output logic [gdc_pkg::OUT_DEPTH_W-1:0] out_depth_now
);
  import gdc_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [2:0]        dir_r, dir_nxt;
  logic              prev_ok_r, prev_ok_nxt;
  logic [3:0]        mask_r, mask_nxt;
  dir_t              sel_r, sel_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  act_t              act_r, act_nxt;
  logic [ROW_W-1:0]  cr_r, cr_nxt, wr_r, wr_nxt;
  logic [COL_W-1:0]  cc_r, cc_nxt, wc_r, wc_nxt;

  logic [1:0]             out_action_r, out_action_nxt;
  logic [OUT_COORD_W-1:0] out_cell_row_r, out_cell_row_nxt;
  logic [OUT_COORD_W-1:0] out_cell_col_r, out_cell_col_nxt;
  logic [OUT_COORD_W-1:0] out_wall_row_r, out_wall_row_nxt;
  logic [OUT_COORD_W-1:0] out_wall_col_r, out_wall_col_nxt;
  logic [OUT_DEPTH_W-1:0] out_depth_r, out_depth_nxt;

  dir_t              su_dir;
  logic              su_far;
  step_t             su_res;
  logic [ADDR_W-1:0] su_addr;

  logic              g_we, g_wdata, g_rdata;
  logic [ADDR_W-1:0] g_waddr;

  logic               s_we;
  logic [SP_W-1:0]    s_waddr, s_raddr;
  logic [ENTRY_W-1:0] s_wdata, s_rdata;
  logic [CNT_W-1:0]   cnt_dec;

  dir_t pick_dir;
  logic in_beat, out_free;

  gdc_step_unit u_step (
    .base_row (row_r),
    .base_col (col_r),
    .dir      (su_dir),
    .far      (su_far),
    .res      (su_res),
    .addr     (su_addr)
  );

  gdc_pick u_pick (
    .mask (mask_r),
    .rnd  (rnd_r),
    .sel  (pick_dir)
  );

  gdc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (su_addr),
    .rdata (g_rdata)
  );

  gdc_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // stack top is read every cycle, so it is ready the cycle after accept
  assign cnt_dec = cnt_r - CNT_W'(1);
  assign s_raddr = cnt_dec[SP_W-1:0];

  assign in_stall = (state_r != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r          <= row_nxt;
    col_r          <= col_nxt;
    dir_r          <= dir_nxt;
    prev_ok_r      <= prev_ok_nxt;
    mask_r         <= mask_nxt;
    sel_r          <= sel_nxt;
    rnd_r          <= rnd_nxt;
    clr_r          <= clr_nxt;
    act_r          <= act_nxt;
    cr_r           <= cr_nxt;
    cc_r           <= cc_nxt;
    wr_r           <= wr_nxt;
    wc_r           <= wc_nxt;
    out_action_r   <= out_action_nxt;
    out_cell_row_r <= out_cell_row_nxt;
    out_cell_col_r <= out_cell_col_nxt;
    out_wall_row_r <= out_wall_row_nxt;
    out_wall_col_r <= out_wall_col_nxt;
    out_depth_r    <= out_depth_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    row_nxt          = row_r;
    col_nxt          = col_r;
    dir_nxt          = dir_r;
    prev_ok_nxt      = prev_ok_r;
    mask_nxt         = mask_r;
    sel_nxt          = sel_r;
    rnd_nxt          = rnd_r;
    clr_nxt          = clr_r;
    act_nxt          = act_r;
    cr_nxt           = cr_r;
    cc_nxt           = cc_r;
    wr_nxt           = wr_r;
    wc_nxt           = wc_r;
    out_action_nxt   = out_action_r;
    out_cell_row_nxt = out_cell_row_r;
    out_cell_col_nxt = out_cell_col_r;
    out_wall_row_nxt = out_wall_row_r;
    out_wall_col_nxt = out_wall_col_r;
    out_depth_nxt    = out_depth_r;
    out_valid_nxt    = out_valid_r && out_stall;

    su_dir  = dir_t'(dir_r[1:0]);
    su_far  = 1'b1;
    g_we    = 1'b0;
    g_waddr = su_addr;
    g_wdata = 1'b1;
    s_we    = 1'b0;
    s_waddr = cnt_r[SP_W-1:0];
    s_wdata = {cr_r, cc_r};

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          rnd_nxt = in_random_value;
          wr_nxt  = '0;
          wc_nxt  = '0;
          if (in_restart) begin
            clr_nxt   = '0;
            state_nxt = ST_CLR;
          end else if (cnt_r == '0) begin
            act_nxt   = ACT_DONE;
            cr_nxt    = '0;
            cc_nxt    = '0;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_TOPRD;
          end
        end
      end
      ST_CLR: begin
        g_we    = 1'b1;
        g_waddr = clr_r;
        g_wdata = 1'b0;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_OPEN11;
        end
      end
      ST_OPEN11: begin
        g_we      = 1'b1;
        g_waddr   = START_ADDR;
        s_we      = 1'b1;
        s_waddr   = '0;
        s_wdata   = {ROW_W'(1), COL_W'(1)};
        cnt_nxt   = CNT_W'(1);
        act_nxt   = ACT_START;
        cr_nxt    = ROW_W'(1);
        cc_nxt    = COL_W'(1);
        state_nxt = ST_EMIT;
      end
      ST_TOPRD: begin
        row_nxt   = s_rdata[ENTRY_W-1:COL_W];
        col_nxt   = s_rdata[COL_W-1:0];
        dir_nxt   = '0;
        mask_nxt  = '0;
        state_nxt = ST_NB;
      end
      ST_NB: begin
        // read for this direction, test the bit read for the one before
        prev_ok_nxt = su_res.ok;
        if (dir_r != 3'd0) begin
          mask_nxt[dir_r[1:0] - 2'd1] = prev_ok_r && !g_rdata;
        end
        dir_nxt = dir_r + 3'd1;
        if (dir_r == 3'd4) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (mask_r == '0) begin
          cnt_nxt   = cnt_dec;
          act_nxt   = ACT_BACK;
          cr_nxt    = row_r;
          cc_nxt    = col_r;
          state_nxt = ST_EMIT;
        end else begin
          sel_nxt   = pick_dir;
          state_nxt = ST_OPENC;
        end
      end
      ST_OPENC: begin
        su_dir    = sel_r;
        g_we      = 1'b1;
        cr_nxt    = su_res.row;
        cc_nxt    = su_res.col;
        state_nxt = ST_OPENW;
      end
      ST_OPENW: begin
        su_dir = sel_r;
        su_far = 1'b0;
        g_we   = 1'b1;
        wr_nxt = su_res.row;
        wc_nxt = su_res.col;
        // a full stack drops the push
        if (cnt_r != CNT_W'(STACK_DEPTH)) begin
          s_we    = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        act_nxt   = ACT_CARVE;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_action_nxt   = act_r;
          out_cell_row_nxt = OUT_COORD_W'(cr_r);
          out_cell_col_nxt = OUT_COORD_W'(cc_r);
          out_wall_row_nxt = OUT_COORD_W'(wr_r);
          out_wall_col_nxt = OUT_COORD_W'(wc_r);
          out_depth_nxt    = (act_r == ACT_DONE) ? '0 : OUT_DEPTH_W'(cnt_r);
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_action    = out_action_r;
  assign out_cell_row  = out_cell_row_r;
  assign out_cell_col  = out_cell_col_r;
  assign out_wall_row  = out_wall_row_r;
  assign out_wall_col  = out_wall_col_r;
  assign out_depth_now = out_depth_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_top_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TOPRD |-> cnt_r != '0)
    else $error("stack top read with empty stack");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_action_r == ACT_DONE |-> out_depth_r == '0 && out_cell_row_r == '0)
    else $error("done result carries nonzero fields");

  a_start_depth: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OPEN11 |=> cnt_r == CNT_W'(1) && state_r == ST_EMIT)
    else $error("restart did not leave one stack entry");

endmodule

[test/maze_carve_checker.sv]
module maze_carve_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_restart,
  input  logic [gdc_pkg::RND_W-1:0]       in_random_value,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      out_action,
  input  logic [gdc_pkg::OUT_COORD_W-1:0] out_cell_row,
  input  logic [gdc_pkg::OUT_COORD_W-1:0] out_cell_col,
  input  logic [gdc_pkg::OUT_COORD_W-1:0] out_wall_row,
  input  logic [gdc_pkg::OUT_COORD_W-1:0] out_wall_col,
  input  logic [gdc_pkg::OUT_DEPTH_W-1:0] out_depth_now,
  output int                              errors,
  output int                              pending
);
  import gdc_pkg::*;

  typedef struct packed {
    act_t                   act;
    logic [OUT_COORD_W-1:0] cell_row;
    logic [OUT_COORD_W-1:0] cell_col;
    logic [OUT_COORD_W-1:0] wall_row;
    logic [OUT_COORD_W-1:0] wall_col;
    logic [OUT_DEPTH_W-1:0] depth;
  } carve_beat_t;

  bit          open_map [GRID_ROWS][GRID_COLS];
  int          trail_row [STACK_DEPTH];
  int          trail_col [STACK_DEPTH];
  int          trail_len;
  int          mismatches = 0;
  carve_beat_t carve_q [$];

  assign errors = mismatches;

  function automatic bit is_wall(int r, int c);
    if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS) return 1'b0;
    return !open_map[r][c];
  endfunction

  function automatic void clear_map();
    for (int r = 0; r < GRID_ROWS; r++)
      for (int c = 0; c < GRID_COLS; c++)
        open_map[r][c] = 1'b0;
  endfunction

  // one restart or search step: updates the grid and trail, returns the beat it should produce
  function automatic carve_beat_t carve_step(bit restart, logic [RND_W-1:0] rnd);
    carve_beat_t b;
    int          cand_r [4];
    int          cand_c [4];
    int          n;
    int          pick;
    int          r;
    int          c;
    int          nr;
    int          nc;
    int          wr;
    int          wc;
    b = '0;
    if (restart) begin
      clear_map();
      open_map[1][1] = 1'b1;
      trail_row[0] = 1;
      trail_col[0] = 1;
      trail_len = 1;
      b.act = ACT_START;
      b.cell_row = OUT_COORD_W'(1);
      b.cell_col = OUT_COORD_W'(1);
      b.depth = OUT_DEPTH_W'(1);
      return b;
    end
    if (trail_len == 0) begin
      b.act = ACT_DONE;
      return b;
    end
    r = trail_row[trail_len - 1];
    c = trail_col[trail_len - 1];
    n = 0;
    for (int i = 0; i < 4; i++) begin
      nr = r;
      nc = c;
      case (dir_t'(i))
        DIR_UP:    nr = r - 2;
        DIR_LEFT:  nc = c - 2;
        DIR_RIGHT: nc = c + 2;
        default:   nr = r + 2;
      endcase
      if (is_wall(nr, nc)) begin
        cand_r[n] = nr;
        cand_c[n] = nc;
        n++;
      end
    end
    if (n == 0) begin
      trail_len--;
      b.act = ACT_BACK;
      b.cell_row = r[OUT_COORD_W-1:0];
      b.cell_col = c[OUT_COORD_W-1:0];
      b.depth = trail_len[OUT_DEPTH_W-1:0];
      return b;
    end
    pick = int'(rnd) % n;
    nr = cand_r[pick];
    nc = cand_c[pick];
    wr = r + (nr - r) / 2;
    wc = c + (nc - c) / 2;
    open_map[nr][nc] = 1'b1;
    open_map[wr][wc] = 1'b1;
    // a carve onto a full trail still opens the cells but drops the push
    if (trail_len < STACK_DEPTH) begin
      trail_row[trail_len] = nr;
      trail_col[trail_len] = nc;
      trail_len++;
    end
    b.act = ACT_CARVE;
    b.cell_row = nr[OUT_COORD_W-1:0];
    b.cell_col = nc[OUT_COORD_W-1:0];
    b.wall_row = wr[OUT_COORD_W-1:0];
    b.wall_col = wc[OUT_COORD_W-1:0];
    b.depth = trail_len[OUT_DEPTH_W-1:0];
    return b;
  endfunction

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    carve_beat_t want;
    carve_beat_t exp_beat;
    if (!rst_n) begin
      clear_map();
      trail_len = 0;
      carve_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (carve_q.size() == 0) begin
          $error("out beat with no expected result waiting");
          mismatches++;
        end else begin
          want = carve_q.pop_front();
          check_field("out_action", 9'(want.act), 9'(out_action));
          check_field("out_cell_row", 9'(want.cell_row), 9'(out_cell_row));
          check_field("out_cell_col", 9'(want.cell_col), 9'(out_cell_col));
          check_field("out_wall_row", 9'(want.wall_row), 9'(out_wall_row));
          check_field("out_wall_col", 9'(want.wall_col), 9'(out_wall_col));
          check_field("out_depth_now", want.depth, out_depth_now);
        end
      end
      if (in_valid && !in_stall) begin
        exp_beat = carve_step(in_restart, in_random_value);
        carve_q = {carve_q, exp_beat};
      end
      pending <= carve_q.size();
    end
  end

endmodule

[test/grid_maze_dfs_carver_core_tb.sv]
module grid_maze_dfs_carver_core_tb;
  import gdc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_ITEMS   = 1600;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_restart = 1'b0;
  logic [RND_W-1:0]       in_random_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             out_action;
  logic [OUT_COORD_W-1:0] out_cell_row;
  logic [OUT_COORD_W-1:0] out_cell_col;
  logic [OUT_COORD_W-1:0] out_wall_row;
  logic [OUT_COORD_W-1:0] out_wall_col;
  logic [OUT_DEPTH_W-1:0] out_depth_now;

  int errors;
  int pending;
  int cycle_cnt = 0;
  int hold_req = 0;
  int holds_served = 0;
  int hold_left = 0;
  bit idle_on = 1'b1;
  int beats_sent = 0;

  grid_maze_dfs_carver_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .in_random_value(in_random_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_cell_row   (out_cell_row),
    .out_cell_col   (out_cell_col),
    .out_wall_row   (out_wall_row),
    .out_wall_col   (out_wall_col),
    .out_depth_now  (out_depth_now)
  );

  maze_carve_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .in_random_value(in_random_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_cell_row   (out_cell_row),
    .out_cell_col   (out_cell_col),
    .out_wall_row   (out_wall_row),
    .out_wall_col   (out_wall_col),
    .out_depth_now  (out_depth_now),
    .errors         (errors),
    .pending        (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_req) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 28);
    end
  end

  task automatic send_beat(input logic restart, input logic [RND_W-1:0] rnd);
    if (idle_on && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    in_random_value <= rnd;
    do @(posedge clk); while (!(in_valid && !in_stall));
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int seg;
    int seg_len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // steps before any restart answer done
    send_beat(1'b0, 16'h0000);
    send_beat(1'b0, 16'hFFFF);
    // restart ignores the random word, also back to back
    send_beat(1'b1, 16'hFFFF);
    send_beat(1'b1, 16'h0000);
    send_beat(1'b0, 16'h0000);
    send_beat(1'b0, 16'h0001);
    send_beat(1'b0, 16'h0002);
    send_beat(1'b0, 16'h0003);
    send_beat(1'b0, 16'hFFFF);
    send_beat(1'b0, 16'h8000);
    send_beat(1'b0, 16'h5555);
    send_beat(1'b0, 16'hAAAA);
    repeat (8) send_beat(1'b0, RND_W'($urandom));
    wait_drained();

    seg = 0;
    while (beats_sent < NUM_ITEMS) begin
      seg++;
      idle_on <= (seg % 4 != 2);
      // a pause until the block has drained
      if (seg % 3 == 0) wait_drained();
      // the first segment, and about a third of the rest, carves a whole maze and runs into done
      if (seg == 1 || $urandom_range(99) < 35)
        seg_len = $urandom_range(515, 560);
      else
        seg_len = $urandom_range(5, 120);
      send_beat(1'b1, RND_W'($urandom));
      for (int i = 0; i < seg_len && beats_sent < NUM_ITEMS; i++) begin
        if (i == 10 && (seg == 2 || seg == 5)) hold_req <= hold_req + 1;
        // stray restarts break off a maze in progress
        send_beat($urandom_range(99) < 2, RND_W'($urandom));
      end
    end

    wait_drained();
    repeat (1100) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
hdl/gdc_pkg.sv
hdl/gdc_ram.sv
hdl/gdc_step_unit.sv
hdl/gdc_pick.sv
hdl/grid_maze_dfs_carver_core.sv
test/maze_carve_checker.sv
test/grid_maze_dfs_carver_core_tb.sv
